@@ sv/dksh_pkg.sv @@
// ----------------------------------------------------------------------------
// dksh_pkg
// Shared types and constants for the dual-key string hash bucket block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dksh_pkg;

  // hash seed and shift rotation constants
  localparam logic [31:0] HASH_SEED = 32'h5555_5555;
  localparam logic [4:0]  SPAN_A    = 5'd24;
  localparam logic [4:0]  SPAN_B    = 5'd23;
  localparam logic [4:0]  STEP_A    = 5'd7;
  localparam logic [4:0]  STEP_B    = 5'd5;

  // word queue depth
  localparam int QUEUE_DEPTH = 2;

  // key pair of one finished word
  typedef struct packed {
    logic [31:0] key_a;
    logic [31:0] key_b;
  } key_pair_t;

  // front to queue push request
  typedef struct packed {
    logic      push;
    key_pair_t keys;
  } queue_push_t;

  // queue status seen by front and back
  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  // back end state machine
  typedef enum logic [2:0] {
    BACK_IDLE   = 3'b001,
    BACK_DIVIDE = 3'b010,
    BACK_DONE   = 3'b100
  } back_state_t;

endpackage

`default_nettype wire

@@ sv/dksh_front.sv @@
// ----------------------------------------------------------------------------
// dksh_front
// Byte hasher: folds one byte per transfer into both keys unless no_char is
// set, and pushes the finished key pair into the word queue on the last byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dksh_front
  import dksh_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [7:0]    char_byte,
  input  wire logic          last_byte,
  input  wire logic          no_char,
  input  wire queue_status_t q_status,
  output queue_push_t        q_push
);

  logic [31:0] acc_a, acc_a_next;
  logic [31:0] acc_b, acc_b_next;
  logic [4:0]  shift_a, shift_a_next;
  logic [4:0]  shift_b, shift_b_next;
  logic        accept;
  logic [4:0]  sum_a, sum_b;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;

  // key update for one byte
  always_comb begin
    sum_a = shift_a + STEP_A;
    sum_b = shift_b + STEP_B;
    acc_a_next   = acc_a;
    acc_b_next   = acc_b;
    shift_a_next = shift_a;
    shift_b_next = shift_b;
    if (!no_char) begin
      acc_a_next   = acc_a ^ ({24'd0, char_byte} << shift_a);
      acc_b_next   = acc_b ^ ({24'd0, char_byte} << shift_b);
      shift_a_next = (sum_a >= SPAN_A) ? sum_a - SPAN_A : sum_a;
      shift_b_next = (sum_b >= SPAN_B) ? sum_b - SPAN_B : sum_b;
    end
  end

  // push finished word
  assign q_push.push       = accept && last_byte;
  assign q_push.keys.key_a = acc_a_next;
  assign q_push.keys.key_b = acc_b_next;

  // hash state, restarts after each word
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_a   <= HASH_SEED;
      acc_b   <= HASH_SEED;
      shift_a <= '0;
      shift_b <= '0;
    end else if (accept) begin
      if (last_byte) begin
        acc_a   <= HASH_SEED;
        acc_b   <= HASH_SEED;
        shift_a <= '0;
        shift_b <= '0;
      end else begin
        acc_a   <= acc_a_next;
        acc_b   <= acc_b_next;
        shift_a <= shift_a_next;
        shift_b <= shift_b_next;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/dksh_queue.sv @@
// ----------------------------------------------------------------------------
// dksh_queue
// Short queue of finished key pairs between the hasher and the divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dksh_queue
  import dksh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire queue_push_t q_push,
  input  wire logic        pop,
  output key_pair_t        head,
  output queue_status_t    q_status
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(QUEUE_DEPTH);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);

  key_pair_t       entries [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign q_status.empty = (count == '0);
  assign q_status.full  = (count == DepthC);
  assign do_push = q_push.push && !q_status.full;
  assign do_pop  = pop && !q_status.empty;
  assign head    = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= q_push.keys;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ sv/dksh_back.sv @@
// ----------------------------------------------------------------------------
// dksh_back
// Bucket stage: takes a key pair from the queue, reduces key B modulo the
// bucket count one quotient bit per cycle, and holds the result for transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dksh_back
  import dksh_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [23:0]   bucket_count,
  input  wire key_pair_t     head,
  input  wire queue_status_t q_status,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [31:0]        key_a,
  output logic [31:0]        key_b,
  output logic [23:0]        bucket_index
);

  back_state_t state, state_next;
  logic [31:0] dividend;
  logic [23:0] rem;
  logic [4:0]  step;
  logic [24:0] trial;
  logic        fits;
  logic [23:0] rem_next;

  assign out_valid = (state == BACK_DONE);
  assign pop       = (state == BACK_IDLE) && !q_status.empty;

  // one restoring division step
  always_comb begin
    trial    = {rem, dividend[31]};
    fits     = (trial >= {1'b0, bucket_count});
    rem_next = fits ? 24'(trial - {1'b0, bucket_count}) : trial[23:0];
  end

  // state sequencing
  always_comb begin
    state_next = state;
    unique case (state)
      BACK_IDLE:   if (!q_status.empty) state_next = BACK_DIVIDE;
      BACK_DIVIDE: if (step == 5'd31) state_next = BACK_DONE;
      BACK_DONE:   if (!out_stall) state_next = BACK_IDLE;
      default:     state_next = BACK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BACK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath: load, iterate, finish
  always_ff @(posedge clk) begin
    unique case (state)
      BACK_IDLE: begin
        key_a    <= head.key_a;
        key_b    <= head.key_b;
        dividend <= head.key_b;
        rem      <= '0;
        step     <= '0;
      end
      BACK_DIVIDE: begin
        dividend <= {dividend[30:0], 1'b0};
        rem      <= rem_next;
        step     <= step + 1'b1;
        if (step == 5'd31) begin
          bucket_index <= (bucket_count == '0) ? '0 : rem_next;
        end
      end
      default: begin
        rem <= rem;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ sv/dual_key_string_hash_bucket.sv @@
// ----------------------------------------------------------------------------
// dual_key_string_hash_bucket
// Two-key byte-stream word hash with bucket index of key B.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------
//  input    | in_valid / in_stall   | char_byte, last_byte, no_char
//  output   | out_valid / out_stall | key_a, key_b, bucket_index
//  config   | cfg_we                | cfg_wdata -> bucket count
//
//  bytes are taken one per cycle while the two-entry word queue has room
//  each word passes through the bucket stage as one load, 32 steps of the
//  bit-serial remainder unit, then the result transfer
//  in_stall rises only when the word queue is full; out_stall holds the result
//  reset empties the queue, reseeds both keys and sets the bucket count to 1
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dual_key_string_hash_bucket
  import dksh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [23:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  char_byte,
  input  wire logic        last_byte,
  input  wire logic        no_char,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      key_a,
  output logic [31:0]      key_b,
  output logic [23:0]      bucket_index
);

  logic [23:0]   bucket_count;
  queue_push_t   q_push;
  queue_status_t q_status;
  key_pair_t     head;
  logic          pop;

  // bucket count register
  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= 24'd1;
    end else if (cfg_we) begin
      bucket_count <= cfg_wdata;
    end
  end

  dksh_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .char_byte (char_byte),
    .last_byte (last_byte),
    .no_char   (no_char),
    .q_status  (q_status),
    .q_push    (q_push)
  );

  dksh_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .q_push   (q_push),
    .pop      (pop),
    .head     (head),
    .q_status (q_status)
  );

  dksh_back u_back (
    .clk          (clk),
    .rst          (rst),
    .bucket_count (bucket_count),
    .head         (head),
    .q_status     (q_status),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .key_a        (key_a),
    .key_b        (key_b),
    .bucket_index (bucket_index)
  );

endmodule

`default_nettype wire

@@ sv/dksh_checker.sv @@
// ----------------------------------------------------------------------------
// dksh_checker
// Port-level checks for the hash bucket block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dksh_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        cfg_we,
  input wire logic [23:0] cfg_wdata,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] key_a,
  input wire logic [31:0] key_b,
  input wire logic [23:0] bucket_index
);

  logic [23:0] count_seen;

  // shadow of the bucket count register
  always_ff @(posedge clk) begin
    if (rst) begin
      count_seen <= 24'd1;
    end else if (cfg_we) begin
      count_seen <= cfg_wdata;
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(key_a) && $stable(key_b)
      && $stable(bucket_index))
    else $error("result changed while stalled");

  // reset leaves no result and an open input
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  // bucket index stays within the bucket count
  a_bucket_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((count_seen == '0) ? (bucket_index == '0)
                                      : (bucket_index < count_seen)))
    else $error("bucket index out of range");

  // a result leaves only by a transfer
  a_out_leave: assert property (@(posedge clk) disable iff (rst)
    $fell(out_valid) |-> $past(!out_stall) || $past(rst))
    else $error("result dropped without transfer");

endmodule

bind dual_key_string_hash_bucket dksh_checker u_dksh_checker (
  .clk          (clk),
  .rst          (rst),
  .cfg_we       (cfg_we),
  .cfg_wdata    (cfg_wdata),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .key_a        (key_a),
  .key_b        (key_b),
  .bucket_index (bucket_index)
);

`default_nettype wire
